// ===== rtl/core/fcw_pkg.sv =====
// Shared types and constants for the FAT16 cluster chain walker.
package fcw_pkg;

  localparam int FCW_TABLE_DEPTH = 65536;

  localparam logic [15:0] FIRST_DATA = 16'd2;
  localparam logic [15:0] FREE_MARK  = 16'h0000;
  localparam logic [15:0] BAD_MARK   = 16'hFFF7;
  localparam logic [15:0] EOC_MIN    = 16'hFFF8;

  typedef enum logic [1:0] {
    CFG_CLU_LIMIT = 2'd0,
    CFG_TABLE_LEN = 2'd1
  } fcw_cfg_idx_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_START = 2'd1,
    REQ_STEP  = 2'd2
  } fcw_req_t;

  typedef enum logic [3:0] {
    ST_STARTED  = 4'd0,
    ST_EMPTY    = 4'd1,
    ST_CONTINUE = 4'd2,
    ST_END      = 4'd3,
    ST_RANGE    = 4'd4,
    ST_FREE     = 4'd5,
    ST_BAD      = 4'd6,
    ST_OUTSIDE  = 4'd7,
    ST_CIRCULAR = 4'd8,
    ST_WRITTEN  = 4'd9,
    ST_IDLE     = 4'd10
  } fcw_status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fcw_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] entry_index;
    logic [15:0] entry_value;
    logic [15:0] first_cluster;
    logic [31:0] byte_size;
  } fcw_in_t;

  typedef struct packed {
    logic [15:0] cluster;
    logic [3:0]  status;
    logic        chain_done;
  } fcw_out_t;

  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;
    logic        rd_en;
    logic [15:0] rd_addr;
  } fcw_ram_cmd_t;

endpackage

// ===== rtl/core/fcw_fat_ram.sv =====
// Allocation table memory: one write port and one registered read port.
module fcw_fat_ram
  import fcw_pkg::*;
#(
  parameter int TABLE_DEPTH = FCW_TABLE_DEPTH
) (
  input  logic         clk,
  input  fcw_ram_cmd_t cmd,
  output logic [15:0]  rd_data
);

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [15:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr[AW-1:0]];
    end
  end

endmodule

// ===== rtl/core/fcw_walk_ctrl.sv =====
// Request sequencer, walk state and result register of the chain walker.
module fcw_walk_ctrl
  import fcw_pkg::*;
#(
  parameter int TABLE_DEPTH = FCW_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  fcw_in_t      in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output fcw_out_t     out_data,
  input  logic [15:0]  clu_limit,
  input  logic [16:0]  table_len,
  output fcw_ram_cmd_t ram_cmd,
  input  logic [15:0]  ram_rd_data
);

  localparam logic [16:0] DEPTH_LIM = 17'(TABLE_DEPTH);

  fcw_state_t  state;
  fcw_state_t  state_next;

  // Request held from the accept cycle to the evaluate cycle.
  logic [1:0]  req_type;
  logic [15:0] req_index;
  logic [15:0] req_first;
  logic        req_size_zero;

  logic [15:0] current_cluster;
  logic [16:0] steps_taken;
  logic        walk_active;

  logic        in_fire;
  logic        slot_free;
  logic        load;

  fcw_out_t    res;
  logic        walk_start;
  logic        walk_stop;
  logic        walk_advance;

  logic [16:0] clu_ext;
  logic        limit_hit;
  logic        range_bad;

  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load     = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: load = slot_free;
      default: begin
        in_ready = 1'b0;
        load     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The write lands in the accept cycle and a step reads in its own accept cycle, so a
  // step that follows a write sees the new value.
  always_comb begin
    ram_cmd.wr_en   = in_fire && (in_data.req_type == REQ_WRITE) &&
                      ({1'b0, in_data.entry_index} < DEPTH_LIM);
    ram_cmd.wr_addr = in_data.entry_index;
    ram_cmd.wr_data = in_data.entry_value;
    ram_cmd.rd_en   = in_fire;
    ram_cmd.rd_addr = current_cluster;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type      <= in_data.req_type;
      req_index     <= in_data.entry_index;
      req_first     <= in_data.first_cluster;
      req_size_zero <= (in_data.byte_size == 32'd0);
    end
  end

  assign clu_ext   = {1'b0, current_cluster};
  assign limit_hit = steps_taken >= {1'b0, clu_limit};
  assign range_bad = (current_cluster < FIRST_DATA) ||
                     (clu_ext >= ({1'b0, clu_limit} + 17'd2)) ||
                     (clu_ext >= table_len) ||
                     (clu_ext >= DEPTH_LIM);

  always_comb begin
    res          = '{cluster: 16'd0, status: ST_IDLE, chain_done: 1'b0};
    walk_start   = 1'b0;
    walk_stop    = 1'b0;
    walk_advance = 1'b0;
    case (req_type)
      REQ_WRITE: begin
        res = '{cluster: req_index, status: ST_WRITTEN, chain_done: 1'b0};
      end
      REQ_START: begin
        if (req_size_zero || req_first == FREE_MARK) begin
          walk_stop = 1'b1;
          res = '{cluster: req_first, status: ST_EMPTY, chain_done: 1'b1};
        end else begin
          walk_start = 1'b1;
          res = '{cluster: req_first, status: ST_STARTED, chain_done: 1'b0};
        end
      end
      REQ_STEP: begin
        if (walk_active) begin
          res.cluster    = current_cluster;
          res.chain_done = 1'b1;
          walk_stop      = 1'b1;
          if (limit_hit) begin
            res.status = ST_CIRCULAR;
          end else if (range_bad) begin
            res.status = ST_RANGE;
          end else if (ram_rd_data >= EOC_MIN) begin
            res.status = ST_END;
          end else if (ram_rd_data == FREE_MARK) begin
            res.status = ST_FREE;
          end else if (ram_rd_data == BAD_MARK) begin
            res.status = ST_BAD;
          end else if ({1'b0, ram_rd_data} >= table_len) begin
            res.status = ST_OUTSIDE;
          end else begin
            res.status     = ST_CONTINUE;
            res.chain_done = 1'b0;
            walk_stop      = 1'b0;
            walk_advance   = 1'b1;
          end
        end
      end
      default: begin
        res = '{cluster: 16'd0, status: ST_IDLE, chain_done: 1'b0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_cluster <= 16'd0;
      steps_taken     <= 17'd0;
      walk_active     <= 1'b0;
    end else if (load) begin
      if (walk_start) begin
        current_cluster <= req_first;
        steps_taken     <= 17'd0;
        walk_active     <= 1'b1;
      end else if (walk_advance) begin
        current_cluster <= ram_rd_data;
        steps_taken     <= steps_taken + 17'd1;
      end else if (walk_stop) begin
        walk_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/core/fat16_cluster_chain_walker.sv =====
// Top level of the FAT16 cluster chain walker.
// The walker keeps a FAT16 allocation table in an on-chip RAM that write beats
// fill, then follows a file's cluster chain one step beat at a time, reporting
// each visited cluster and how the walk ended. In a beat's accept cycle the
// table RAM is read at the current cluster, and written on a write beat; in
// the next cycle the returned entry is checked and the result is loaded into
// the output register once the output is free. The RAM read is registered and
// each step needs the entry found by the previous step, so beats do not
// overlap. A new beat is accepted while the last result still waits on the
// output; only a result that cannot leave holds the walker in its evaluate
// cycle. The table has no reset and no clearing pass, so it is ready right
// after reset; entries must be written before a walk reads them. Configuration
// writes are accepted in every cycle and belong in idle periods.
module fat16_cluster_chain_walker
  import fcw_pkg::*;
#(
  parameter int TABLE_DEPTH = FCW_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fcw_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output fcw_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic [15:0]  clu_limit;
  logic [16:0]  table_len;
  fcw_ram_cmd_t ram_cmd;
  logic [15:0]  ram_rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clu_limit <= 16'd0;
      table_len <= 17'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLU_LIMIT: clu_limit <= cfg_data[15:0];
        CFG_TABLE_LEN: table_len <= cfg_data;
        default: begin
          clu_limit <= clu_limit;
          table_len <= table_len;
        end
      endcase
    end
  end

  fcw_fat_ram #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .cmd     (ram_cmd),
    .rd_data (ram_rd_data)
  );

  fcw_walk_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .clu_limit   (clu_limit),
    .table_len   (table_len),
    .ram_cmd     (ram_cmd),
    .ram_rd_data (ram_rd_data)
  );

endmodule

// ===== rtl/core/fcw_checker.sv =====
// Port-level checks for the chain walker, bound to the top level.
module fcw_checker
  import fcw_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input fcw_out_t out_data
);

  // No beat is accepted while one is evaluated, so accepts never come back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in two consecutive cycles");

  a_done_matches_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.chain_done == (out_data.status == ST_EMPTY ||
      out_data.status == ST_END || out_data.status == ST_RANGE ||
      out_data.status == ST_FREE || out_data.status == ST_BAD ||
      out_data.status == ST_OUTSIDE || out_data.status == ST_CIRCULAR))
    else $error("chain_done does not agree with status");

  a_idle_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_IDLE |-> out_data.cluster == 16'd0)
    else $error("idle result carries a nonzero cluster");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");

endmodule

bind fat16_cluster_chain_walker fcw_checker u_fcw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
